// ----- hdl/evr_pkg.sv -----
`timescale 1ns / 1ps

package evr_pkg;

  localparam int COORD_BITS      = 24;
  localparam int COEF_BITS       = 18;
  localparam int SINE_TABLE_BITS = 10;
  localparam int FRAC_BITS       = COEF_BITS - 2;
  localparam int ANGLE_BITS      = 16;
  localparam int CFG_IDX_BITS    = 2;

  localparam int PROD_BITS    = COEF_BITS + COORD_BITS;
  localparam int SUM_BITS     = PROD_BITS + 2;
  localparam int MUL_BITS     = 2 * COEF_BITS;
  localparam int ACC_BITS     = MUL_BITS + 2;
  localparam int MAT_SIZE     = 9;
  localparam int MAT_IDX_BITS = $clog2(MAT_SIZE);

  localparam int QTR_BITS    = SINE_TABLE_BITS - 2;
  localparam int QTR_LEN     = 1 << QTR_BITS;
  localparam int PHASE_SHIFT = ANGLE_BITS - SINE_TABLE_BITS;

  localparam int NUM_STEPS = 15;
  localparam int STEP_BITS = $clog2(NUM_STEPS);

  localparam longint K_A1 = 64'sd1686629713;
  localparam longint K_A3 = -64'sd693598668;
  localparam longint K_A5 = 64'sd85569306;
  localparam longint K_A7 = -64'sd5026995;
  localparam longint K_A9 = 64'sd172272;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic [FRAC_BITS:0]          sine_mag_t;
  typedef logic [ANGLE_BITS-1:0]       angle_t;
  typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic signed [COORD_BITS-1:0] vert_z;
    logic                         last_in;
  } vert_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rot_x;
    logic signed [COORD_BITS-1:0] rot_y;
    logic signed [COORD_BITS-1:0] rot_z;
    logic                         last_out;
  } vert_out_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ANGLE_Z = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_X = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_LOAD,
    GS_RUN,
    GS_DRAIN
  } gen_state_e;

  typedef enum logic [3:0] {
    OPD_SZ,
    OPD_CZ,
    OPD_SY,
    OPD_CY,
    OPD_SX,
    OPD_CX,
    OPD_CZSY,
    OPD_SZSY,
    OPD_ONE
  } opd_e;

  typedef enum logic [1:0] {
    ACC_SET,
    ACC_NEG,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    DST_M0   = 4'd0,
    DST_M1   = 4'd1,
    DST_M2   = 4'd2,
    DST_M3   = 4'd3,
    DST_M4   = 4'd4,
    DST_M5   = 4'd5,
    DST_M6   = 4'd6,
    DST_M7   = 4'd7,
    DST_M8   = 4'd8,
    DST_CZSY = 4'd9,
    DST_SZSY = 4'd10,
    DST_NONE = 4'd15
  } dest_e;

  typedef struct packed {
    opd_e    a_sel;
    opd_e    b_sel;
    acc_op_e op;
    dest_e   dst;
  } step_t;

  localparam coef_t     ONE_COEF = coef_t'(longint'(1) << FRAC_BITS);
  localparam sine_mag_t ONE_MAG  = sine_mag_t'(longint'(1) << FRAC_BITS);

  function automatic sine_mag_t quarter_sine(longint q);
    longint x;
    longint x2;
    longint acc;
    longint s;
    if (q <= 0) begin
      return '0;
    end
    if (q >= 16384) begin
      return ONE_MAG;
    end
    x   = q * 4;
    x2  = (x * x) >>> 16;
    acc = K_A9;
    acc = K_A7 + ((acc * x2) >>> 16);
    acc = K_A5 + ((acc * x2) >>> 16);
    acc = K_A3 + ((acc * x2) >>> 16);
    acc = K_A1 + ((acc * x2) >>> 16);
    s   = (acc * x + (longint'(1) << (45 - FRAC_BITS))) >>> (46 - FRAC_BITS);
    if (s < 0) begin
      s = 0;
    end
    if (s > (longint'(1) << FRAC_BITS)) begin
      s = longint'(1) << FRAC_BITS;
    end
    return sine_mag_t'(s);
  endfunction

  typedef sine_mag_t sine_tab_t [QTR_LEN];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < QTR_LEN; i++) begin
      t[i] = quarter_sine(longint'(i) << PHASE_SHIFT);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic coef_t phase_sine(angle_t p);
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] idx;
    logic [QTR_BITS-1:0] ridx;
    sine_mag_t           mag;
    coef_t               s;
    quad = p[ANGLE_BITS-1 -: 2];
    idx  = p[ANGLE_BITS-3 -: QTR_BITS];
    ridx = '0 - idx;
    if (quad[0]) begin
      mag = (idx == '0) ? ONE_MAG : SINE_TAB[ridx];
    end else begin
      mag = SINE_TAB[idx];
    end
    s = coef_t'(mag);
    if (quad[1]) begin
      s = -s;
    end
    return s;
  endfunction

  function automatic step_t micro_step(logic [STEP_BITS-1:0] k);
    step_t st;
    st = '{a_sel: OPD_ONE, b_sel: OPD_ONE, op: ACC_SET, dst: DST_NONE};
    case (k)
      4'd0:  st = '{a_sel: OPD_CZ,   b_sel: OPD_SY,  op: ACC_SET, dst: DST_CZSY};
      4'd1:  st = '{a_sel: OPD_SZ,   b_sel: OPD_SY,  op: ACC_SET, dst: DST_SZSY};
      4'd2:  st = '{a_sel: OPD_CZ,   b_sel: OPD_CY,  op: ACC_SET, dst: DST_M0};
      4'd3:  st = '{a_sel: OPD_CZSY, b_sel: OPD_SX,  op: ACC_SET, dst: DST_NONE};
      4'd4:  st = '{a_sel: OPD_SZ,   b_sel: OPD_CX,  op: ACC_SUB, dst: DST_M1};
      4'd5:  st = '{a_sel: OPD_CZSY, b_sel: OPD_CX,  op: ACC_SET, dst: DST_NONE};
      4'd6:  st = '{a_sel: OPD_SZ,   b_sel: OPD_SX,  op: ACC_ADD, dst: DST_M2};
      4'd7:  st = '{a_sel: OPD_SZ,   b_sel: OPD_CY,  op: ACC_SET, dst: DST_M3};
      4'd8:  st = '{a_sel: OPD_SZSY, b_sel: OPD_SX,  op: ACC_SET, dst: DST_NONE};
      4'd9:  st = '{a_sel: OPD_CZ,   b_sel: OPD_CX,  op: ACC_ADD, dst: DST_M4};
      4'd10: st = '{a_sel: OPD_SZSY, b_sel: OPD_CX,  op: ACC_SET, dst: DST_NONE};
      4'd11: st = '{a_sel: OPD_CZ,   b_sel: OPD_SX,  op: ACC_SUB, dst: DST_M5};
      4'd12: st = '{a_sel: OPD_SY,   b_sel: OPD_ONE, op: ACC_NEG, dst: DST_M6};
      4'd13: st = '{a_sel: OPD_CY,   b_sel: OPD_SX,  op: ACC_SET, dst: DST_M7};
      4'd14: st = '{a_sel: OPD_CY,   b_sel: OPD_CX,  op: ACC_SET, dst: DST_M8};
      default: st = '{a_sel: OPD_ONE, b_sel: OPD_ONE, op: ACC_SET, dst: DST_NONE};
    endcase
    return st;
  endfunction

endpackage

// ----- hdl/evr_coef_gen.sv -----
`timescale 1ns / 1ps

module evr_coef_gen (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  evr_pkg::cfg_idx_t cfg_idx_i,
  input  evr_pkg::angle_t   cfg_wdata_i,
  output logic              busy_o,
  output evr_pkg::coef_t    coef_o [evr_pkg::MAT_SIZE]
);
  import evr_pkg::*;

  angle_t     angle_z_q, angle_y_q, angle_x_q;
  coef_t      sz_q, cz_q, sy_q, cy_q, sx_q, cx_q;
  coef_t      czsy_q, szsy_q;
  coef_t      coef_q [MAT_SIZE];
  gen_state_e state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic       cfg_hit;
  logic       issue;
  step_t      cur;
  coef_t      opa, opb;
  logic signed [MUL_BITS-1:0] prod_d, prod_q;
  logic       mul_vld_q;
  acc_op_e    mul_op_q;
  dest_e      mul_dst_q;
  logic signed [ACC_BITS-1:0] acc_q, acc_d, acc_base, rnd_sum, rnd_shift;
  logic [ACC_BITS-COEF_BITS:0] rnd_hi;
  coef_t      coef_rnd;
  logic       coef_we;
  logic [MAT_IDX_BITS-1:0] coef_idx;

  localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_STEPS - 1);

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_ANGLE_Z || cfg_idx_i == REG_ANGLE_Y ||
                                cfg_idx_i == REG_ANGLE_X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_z_q <= '0;
      angle_y_q <= '0;
      angle_x_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ANGLE_Z: angle_z_q <= cfg_wdata_i;
        REG_ANGLE_Y: angle_y_q <= cfg_wdata_i;
        REG_ANGLE_X: angle_x_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    sz_q <= phase_sine(angle_z_q);
    cz_q <= phase_sine(angle_z_q + angle_t'(1 << (ANGLE_BITS - 2)));
    sy_q <= phase_sine(angle_y_q);
    cy_q <= phase_sine(angle_y_q + angle_t'(1 << (ANGLE_BITS - 2)));
    sx_q <= phase_sine(angle_x_q);
    cx_q <= phase_sine(angle_x_q + angle_t'(1 << (ANGLE_BITS - 2)));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      GS_IDLE:  state_d = GS_IDLE;
      GS_LOAD:  state_d = GS_RUN;
      GS_RUN:   state_d = (step_q == LAST_STEP) ? GS_DRAIN : GS_RUN;
      GS_DRAIN: state_d = GS_IDLE;
      default:  state_d = GS_IDLE;
    endcase
    if (cfg_hit) begin
      state_d = GS_LOAD;
    end
  end

  always_comb begin
    busy_o = 1'b1;
    issue  = 1'b0;
    case (state_q)
      GS_IDLE:  busy_o = 1'b0;
      GS_LOAD:  busy_o = 1'b1;
      GS_RUN:   issue  = 1'b1;
      GS_DRAIN: busy_o = 1'b1;
      default:  busy_o = 1'b0;
    endcase
  end

  assign step_d = (issue && !cfg_hit) ? step_q + STEP_BITS'(1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= GS_IDLE;
      step_q    <= '0;
      mul_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      mul_vld_q <= issue;
    end
  end

  assign cur = micro_step(step_q);

  always_comb begin
    case (cur.a_sel)
      OPD_SZ:   opa = sz_q;
      OPD_CZ:   opa = cz_q;
      OPD_SY:   opa = sy_q;
      OPD_CY:   opa = cy_q;
      OPD_SX:   opa = sx_q;
      OPD_CX:   opa = cx_q;
      OPD_CZSY: opa = czsy_q;
      OPD_SZSY: opa = szsy_q;
      OPD_ONE:  opa = ONE_COEF;
      default:  opa = ONE_COEF;
    endcase
  end

  always_comb begin
    case (cur.b_sel)
      OPD_SZ:   opb = sz_q;
      OPD_CZ:   opb = cz_q;
      OPD_SY:   opb = sy_q;
      OPD_CY:   opb = cy_q;
      OPD_SX:   opb = sx_q;
      OPD_CX:   opb = cx_q;
      OPD_CZSY: opb = czsy_q;
      OPD_SZSY: opb = szsy_q;
      OPD_ONE:  opb = ONE_COEF;
      default:  opb = ONE_COEF;
    endcase
  end

  assign prod_d = MUL_BITS'(opa) * MUL_BITS'(opb);

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    mul_op_q  <= cur.op;
    mul_dst_q <= cur.dst;
    if (mul_vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_base = (mul_op_q == ACC_SET || mul_op_q == ACC_NEG) ? '0 : acc_q;
    if (mul_op_q == ACC_SET || mul_op_q == ACC_ADD) begin
      acc_d = acc_base + ACC_BITS'(prod_q);
    end else begin
      acc_d = acc_base - ACC_BITS'(prod_q);
    end
    rnd_sum   = acc_d + ACC_HALF;
    rnd_shift = rnd_sum >>> FRAC_BITS;
    rnd_hi    = rnd_shift[ACC_BITS-1:COEF_BITS-1];
    if (&rnd_hi || ~|rnd_hi) begin
      coef_rnd = rnd_shift[COEF_BITS-1:0];
    end else begin
      coef_rnd = {rnd_shift[ACC_BITS-1], {(COEF_BITS-1){~rnd_shift[ACC_BITS-1]}}};
    end
  end

  assign coef_we  = mul_vld_q && (mul_dst_q <= DST_M8);
  assign coef_idx = mul_dst_q[MAT_IDX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (mul_vld_q && mul_dst_q == DST_CZSY) begin
      czsy_q <= coef_rnd;
    end
    if (mul_vld_q && mul_dst_q == DST_SZSY) begin
      szsy_q <= coef_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_SIZE; i++) begin
        coef_q[i] <= ((i % 4) == 0) ? ONE_COEF : '0;
      end
    end else if (coef_we) begin
      coef_q[coef_idx] <= coef_rnd;
    end
  end

  assign coef_o = coef_q;

endmodule

// ----- hdl/euler_vertex_rotation_core.sv -----
`timescale 1ns / 1ps

// Rotates a stream of Q16.8 vertices by the matrix Rz*Ry*Rx built from the three angle
// registers; each vertex leaves rounded half up and saturated, with its last flag, through
// a three-register pipeline (product registers, row-sum registers, and the output register
// that takes the rounded and saturated rows) that takes one vertex every cycle while the
// output is not stalled and no register write or matrix rebuild is in progress. A write to
// an angle register starts the coefficient builder, which runs the fifteen matrix products
// through one shared multiplier: in_ready_o stays low from the write cycle through its load,
// run and drain states, after which the new matrix applies to every later vertex.
module euler_vertex_rotation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  evr_pkg::vert_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output evr_pkg::vert_out_t out_data_o,
  input  logic               cfg_we_i,
  input  evr_pkg::cfg_idx_t  cfg_idx_i,
  input  evr_pkg::angle_t    cfg_wdata_i
);
  import evr_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SUM_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);

  coef_t     coef [MAT_SIZE];
  logic      gen_busy;
  logic      en1, en2, en3, in_acc;
  logic      v1_q, v2_q, v3_q;
  logic      last1_q, last2_q;
  logic signed [COORD_BITS-1:0] vert_c [3];
  logic signed [PROD_BITS-1:0]  prod1_q [MAT_SIZE];
  logic signed [SUM_BITS-1:0]   sum2_q [3];
  vert_out_t out_q;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0]     sh;
    logic [SUM_BITS-COORD_BITS:0]   hi;
    sh = v >>> FRAC_BITS;
    hi = sh[SUM_BITS-1:COORD_BITS-1];
    if (&hi || ~|hi) begin
      return sh[COORD_BITS-1:0];
    end
    return {sh[SUM_BITS-1], {(COORD_BITS-1){~sh[SUM_BITS-1]}}};
  endfunction

  evr_coef_gen u_coef_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (gen_busy),
    .coef_o      (coef)
  );

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !gen_busy && !cfg_we_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign vert_c[0] = in_data_i.vert_x;
  assign vert_c[1] = in_data_i.vert_y;
  assign vert_c[2] = in_data_i.vert_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      last1_q <= in_data_i.last_in;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod1_q[j*3+i] <= PROD_BITS'(coef[j*3+i]) * PROD_BITS'(vert_c[i]);
        end
      end
    end
    if (en2) begin
      last2_q <= last1_q;
      for (int j = 0; j < 3; j++) begin
        sum2_q[j] <= SUM_BITS'(prod1_q[j*3]) + SUM_BITS'(prod1_q[j*3+1])
                   + SUM_BITS'(prod1_q[j*3+2]) + SUM_HALF;
      end
    end
    if (en3) begin
      out_q.rot_x    <= sat_coord(sum2_q[0]);
      out_q.rot_y    <= sat_coord(sum2_q[1]);
      out_q.rot_z    <= sat_coord(sum2_q[2]);
      out_q.last_out <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/evr_checker.sv -----
`timescale 1ns / 1ps

module evr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input evr_pkg::vert_in_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input evr_pkg::vert_out_t out_data_o,
  input logic               cfg_we_i,
  input evr_pkg::cfg_idx_t  cfg_idx_i
);
  import evr_pkg::*;

  localparam int BUILD_TAIL = NUM_STEPS + 2;

  logic angle_wr;

  assign angle_wr = cfg_we_i && (cfg_idx_i == REG_ANGLE_Z || cfg_idx_i == REG_ANGLE_Y ||
                                 cfg_idx_i == REG_ANGLE_X);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction dropped or changed while stalled");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_ready_o)
    else $error("input accepted in a register write cycle");

  a_build_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_wr |-> ##BUILD_TAIL !in_ready_o)
    else $error("input accepted before the matrix rebuild finished");

endmodule

bind euler_vertex_rotation_core evr_checker u_evr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);

// ----- tb/evr_rotation_checker.sv -----
`timescale 1ns / 1ps

module evr_rotation_checker
  import evr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  vert_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  vert_out_t out_data_i,
  input  logic      cfg_we_i,
  input  cfg_idx_t  cfg_idx_i,
  input  angle_t    cfg_wdata_i,
  output int        pending_o,
  output int        errors_o,
  output int        checked_o
);

  localparam int     REPORT_MAX = 10;
  localparam longint UNIT       = longint'(1) << FRAC_BITS;
  localparam longint HALF_LSB   = longint'(1) << (FRAC_BITS - 1);
  localparam longint QUARTER    = 16384;
  localparam angle_t PHASE_MASK =
    angle_t'(~((32'd1 << (ANGLE_BITS - SINE_TABLE_BITS)) - 32'd1));

  localparam longint POLY_A1 = 1686629713;
  localparam longint POLY_A3 = -693598668;
  localparam longint POLY_A5 = 85569306;
  localparam longint POLY_A7 = -5026995;
  localparam longint POLY_A9 = 172272;

  angle_t    ang_z;
  angle_t    ang_y;
  angle_t    ang_x;
  longint    coef [9];
  vert_out_t rotated_q [$];
  vert_out_t got;
  vert_out_t want;
  int        err_total;
  int        n_checked;

  function automatic longint saturate(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint round_unit(longint v);
    return (v + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic longint quarter_wave(longint q);
    longint x;
    longint x2;
    longint acc;
    longint s;
    if (q <= 0) begin
      return 0;
    end
    if (q >= QUARTER) begin
      return UNIT;
    end
    x   = q * 4;
    x2  = (x * x) >>> 16;
    acc = POLY_A7 + ((POLY_A9 * x2) >>> 16);
    acc = POLY_A5 + ((acc * x2) >>> 16);
    acc = POLY_A3 + ((acc * x2) >>> 16);
    acc = POLY_A1 + ((acc * x2) >>> 16);
    s   = (acc * x + (longint'(1) << (45 - FRAC_BITS))) >>> (46 - FRAC_BITS);
    if (s < 0) begin
      s = 0;
    end
    if (s > UNIT) begin
      s = UNIT;
    end
    return s;
  endfunction

  function automatic longint angle_sine(angle_t p);
    longint r;
    longint mag;
    r   = longint'(p[ANGLE_BITS-3:0]);
    mag = p[ANGLE_BITS-2] ? quarter_wave(QUARTER - r) : quarter_wave(r);
    return p[ANGLE_BITS-1] ? -mag : mag;
  endfunction

  function automatic void load_rotation();
    angle_t pz;
    angle_t py;
    angle_t px;
    longint sz;
    longint cz;
    longint sy;
    longint cy;
    longint sx;
    longint cx;
    longint czsy;
    longint szsy;
    longint m [9];
    pz   = ang_z & PHASE_MASK;
    py   = ang_y & PHASE_MASK;
    px   = ang_x & PHASE_MASK;
    sz   = angle_sine(pz);
    cz   = angle_sine(pz + angle_t'(QUARTER));
    sy   = angle_sine(py);
    cy   = angle_sine(py + angle_t'(QUARTER));
    sx   = angle_sine(px);
    cx   = angle_sine(px + angle_t'(QUARTER));
    czsy = round_unit(cz * sy);
    szsy = round_unit(sz * sy);
    m[0] = round_unit(cz * cy);
    m[1] = round_unit(czsy * sx - sz * cx);
    m[2] = round_unit(czsy * cx + sz * sx);
    m[3] = round_unit(sz * cy);
    m[4] = round_unit(szsy * sx + cz * cx);
    m[5] = round_unit(szsy * cx - cz * sx);
    m[6] = -sy;
    m[7] = round_unit(cy * sx);
    m[8] = round_unit(cy * cx);
    for (int i = 0; i < 9; i++) begin
      coef[i] = saturate(m[i], COEF_BITS);
    end
  endfunction

  function automatic longint row_dot(int row, vert_in_t v);
    longint acc;
    acc = coef[3*row]     * longint'($signed(v.vert_x))
        + coef[3*row + 1] * longint'($signed(v.vert_y))
        + coef[3*row + 2] * longint'($signed(v.vert_z));
    return saturate(round_unit(acc), COORD_BITS);
  endfunction

  function automatic vert_out_t rotate_vertex(vert_in_t v);
    vert_out_t r;
    r.rot_x    = COORD_BITS'(row_dot(0, v));
    r.rot_y    = COORD_BITS'(row_dot(1, v));
    r.rot_z    = COORD_BITS'(row_dot(2, v));
    r.last_out = v.last_in;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_z     = '0;
      ang_y     = '0;
      ang_x     = '0;
      load_rotation();
      rotated_q.delete();
      err_total = 0;
      n_checked = 0;
      pending_o <= 0;
      errors_o  <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANGLE_Z: ang_z = cfg_wdata_i;
          REG_ANGLE_Y: ang_y = cfg_wdata_i;
          REG_ANGLE_X: ang_x = cfg_wdata_i;
          default: ;
        endcase
        load_rotation();
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (rotated_q.size() == 0) begin
          err_total++;
          if (err_total <= REPORT_MAX) begin
            $display("%0t: unexpected vertex out (%0d, %0d, %0d, last %0b)", $time,
                     $signed(got.rot_x), $signed(got.rot_y), $signed(got.rot_z),
                     got.last_out);
          end
        end else begin
          want = rotated_q.pop_front();
          n_checked++;
          if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
              got.rot_z !== want.rot_z || got.last_out !== want.last_out) begin
            err_total++;
            if (err_total <= REPORT_MAX) begin
              $display("%0t: vertex %0d expected (%0d, %0d, %0d, last %0b) got (%0d, %0d, %0d, last %0b)",
                       $time, n_checked,
                       $signed(want.rot_x), $signed(want.rot_y), $signed(want.rot_z),
                       want.last_out,
                       $signed(got.rot_x), $signed(got.rot_y), $signed(got.rot_z),
                       got.last_out);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        rotated_q.push_back(rotate_vertex(in_data_i));
      end
      pending_o <= rotated_q.size();
      errors_o  <= err_total;
      checked_o <= n_checked;
    end
  end

endmodule

// ----- tb/euler_vertex_rotation_core_tb.sv -----
`timescale 1ns / 1ps

module euler_vertex_rotation_core_tb;
  import evr_pkg::*;

  localparam int       CYCLE_LIMIT   = 200000;
  localparam int       SETTING_ITEMS = 125;
  localparam int       SETTLE_CYCLES = 4;
  localparam cfg_idx_t REG_UNUSED    = 2'd3;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  vert_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  vert_out_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_t  cfg_idx_i   = REG_ANGLE_Z;
  angle_t    cfg_wdata_i = '0;

  int pending;
  int errors;
  int checked;
  int burst_left  = 0;
  int sent_cnt    = 0;
  int last_cnt    = 0;
  int setting_cnt = 0;
  int hold_cnt    = 0;
  int cycles      = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  euler_vertex_rotation_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  evr_rotation_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors),
    .checked_o   (checked)
  );

  function automatic vert_in_t mk_vertex(int x, int y, int z, logic last);
    vert_in_t v;
    v.vert_x  = COORD_BITS'(x);
    v.vert_y  = COORD_BITS'(y);
    v.vert_z  = COORD_BITS'(z);
    v.last_in = last;
    return v;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return COORD_BITS'(1);
      default: return '1;
    endcase
  endfunction

  function automatic vert_in_t random_vertex();
    vert_in_t v;
    int       kind;
    kind   = $urandom_range(0, 9);
    v.vert_x = COORD_BITS'($urandom());
    v.vert_y = COORD_BITS'($urandom());
    v.vert_z = COORD_BITS'($urandom());
    if (kind >= 5 && kind <= 7) begin
      v.vert_x = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
      v.vert_y = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
      v.vert_z = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
    end else if (kind == 8) begin
      v.vert_x = extreme_coord();
      v.vert_y = extreme_coord();
      v.vert_z = extreme_coord();
    end else if (kind == 9) begin
      v.vert_x = COORD_BITS'(C_MAX - $urandom_range(0, 255));
      v.vert_y = COORD_BITS'(C_MIN + $urandom_range(0, 255));
      v.vert_z = $urandom_range(0, 1) ? C_MAX : C_MIN;
    end
    v.last_in = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  task automatic offer_vertex(input vert_in_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    if (v.last_in) begin
      last_cnt++;
    end
  endtask

  task automatic write_angle(input cfg_idx_t idx, input angle_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_directed();
    offer_vertex(mk_vertex(0, 0, 0, 1'b0));
    offer_vertex(mk_vertex(C_MAX, C_MAX, C_MAX, 1'b1));
    offer_vertex(mk_vertex(C_MIN, C_MIN, C_MIN, 1'b0));
    offer_vertex(mk_vertex(C_MAX, C_MIN, 0, 1'b0));
    offer_vertex(mk_vertex(C_MIN, C_MAX, C_MAX, 1'b1));
    offer_vertex(mk_vertex(0, C_MAX, C_MIN, 1'b0));
    offer_vertex(mk_vertex(1, -1, 1, 1'b0));
    offer_vertex(mk_vertex(-1, 1, -1, 1'b1));
    offer_vertex(mk_vertex(256, 512, -768, 1'b0));
    offer_vertex(mk_vertex(C_MAX, 0, 0, 1'b0));
    offer_vertex(mk_vertex(0, C_MIN, 0, 1'b0));
    offer_vertex(mk_vertex(0, 0, C_MAX, 1'b1));
  endtask

  task automatic run_setting(input angle_t az, input angle_t ay, input angle_t ax,
                             input bit reprogram, input bit with_directed);
    if (reprogram) begin
      write_angle(REG_ANGLE_Z, az);
      write_angle(REG_ANGLE_Y, ay);
      write_angle(REG_ANGLE_X, ax);
    end
    setting_cnt++;
    if (with_directed) begin
      send_directed();
    end
    repeat (SETTING_ITEMS) offer_vertex(random_vertex());
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("euler_vertex_rotation_core_tb: FAIL");
    $finish;
  end

  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       until_hold;
    until_hold = 300;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (until_hold <= 0) begin
        while (!in_valid_i) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end
        out_ready_i <= 1'b0;
        repeat ($urandom_range(150, 300)) @(posedge clk_i);
        hold_cnt++;
        until_hold = $urandom_range(1500, 3000);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 150);
      repeat (span) begin
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ~out_ready_i;
        endcase
        @(posedge clk_i);
        until_hold--;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_setting(16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    run_setting(16'd8192, 16'd8192, 16'd8192, 1'b1, 1'b1);
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    run_setting(16'd16384, 16'd0, 16'd0, 1'b1, 1'b0);
    run_setting(16'd0, 16'd16384, 16'd0, 1'b1, 1'b0);
    run_setting(16'd0, 16'd0, 16'd16384, 1'b1, 1'b0);
    run_setting(16'd32768, 16'd32768, 16'd32768, 1'b1, 1'b0);
    run_setting(16'd49152, 16'd49152, 16'd49152, 1'b1, 1'b0);
    run_setting(16'h003F, 16'h0040, 16'hFFC0, 1'b1, 1'b0);
    write_angle(REG_UNUSED, angle_t'($urandom()));
    run_setting(angle_t'($urandom()), angle_t'($urandom()), angle_t'($urandom()), 1'b1, 1'b0);
    write_angle(REG_UNUSED, 16'hFFFF);
    run_setting(angle_t'($urandom()), angle_t'($urandom()), angle_t'($urandom()), 1'b1, 1'b0);
    run_setting(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    $display("Rotated %0d vertices (%0d closing a figure) under %0d angle settings,",
             sent_cnt, last_cnt, setting_cnt);
    $display("with saturating corners, quantized angles, %0d checked, %0d long output stalls.",
             checked, hold_cnt);
    if (errors == 0 && pending == 0) begin
      $display("euler_vertex_rotation_core_tb: PASS");
    end else begin
      $display("euler_vertex_rotation_core_tb: FAIL");
    end
    $finish;
  end

endmodule
